### design/stse_pkg.sv
// Shared types, sizes and codes for the segment tree sum engine.
package stse_pkg;

  localparam int LEAVES = 1024;
  localparam int LEAF_W = $clog2(LEAVES);
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int ADDR_W = $clog2(NODES);
  // 1-based heap index; query bounds reach up to 3*LEAVES-1
  localparam int HEAP_W = LEAF_W + 2;
  localparam int SUM_W  = 64;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic signed [SUM_W-1:0] value;
  } stse_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_out;
    logic [POS_W-1:0]        position_out;
  } stse_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_LEAF,
    ST_ADD_UP,
    ST_ROOT_RD,
    ST_QRY,
    ST_SRCH,
    ST_FINISH
  } state_t;

endpackage

### design/segment_tree_sum_engine_top.sv
// Segment tree sum engine: node sums in one RAM, walked by a sequencer.
//
//  channel | direction | handshake            | beat
//  in      | input     | in_valid / in_ready  | stse_in_t  (action, indexes, value)
//  out     | output    | out_valid / out_ready| stse_out_t (sum, position)
//
// Every tree read goes through the single read port of the node RAM (one read a cycle).
// Add: leaf read, then one sibling read per level up to the root, then finish.
// Query: up to two node reads and one shift per level.
// Search: one leaf a cycle from the start leaf up to the last leaf.
// After reset a clearing pass writes zero to all 2*LEAVES-1 nodes before
// in_ready rises. A result waiting in the output register holds the next one in FINISH.
module segment_tree_sum_engine_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  stse_pkg::stse_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stse_pkg::stse_out_t out_data
);
  import stse_pkg::*;

  state_t state, state_next;

  logic [ADDR_W-1:0]       clr_addr, clr_addr_next;
  logic [HEAP_W-1:0]       ql, ql_next;
  logic [HEAP_W-1:0]       qr, qr_next;
  logic [HEAP_W-1:0]       hk, hk_next;
  logic [LEAF_W-1:0]       dj, dj_next;
  logic                    pend, pend_next;
  logic [SUM_W-1:0]        acc, acc_next;
  logic [SUM_W-1:0]        cur, cur_next;
  logic [SUM_W-1:0]        delta, delta_next;
  logic signed [SUM_W-1:0] thresh, thresh_next;
  logic [SUM_W-1:0]        res_sum, res_sum_next;
  logic [POS_W-1:0]        res_pos, res_pos_next;
  stse_out_t               out_reg, out_reg_next;
  logic                    out_vld, out_vld_next;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [SUM_W-1:0]  wdata;
  logic [ADDR_W-1:0] raddr;
  logic [SUM_W-1:0]  rdata;

  logic [SUM_W-1:0]  sum_tmp;
  logic [HEAP_W-1:0] parent;
  logic [HEAP_W-1:0] hi_sat;

  stse_ram #(
    .DEPTH  (NODES),
    .WIDTH  (SUM_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_vld;
  assign out_data  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      out_vld  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      out_vld  <= out_vld_next;
    end
    ql      <= ql_next;
    qr      <= qr_next;
    hk      <= hk_next;
    dj      <= dj_next;
    pend    <= pend_next;
    acc     <= acc_next;
    cur     <= cur_next;
    delta   <= delta_next;
    thresh  <= thresh_next;
    res_sum <= res_sum_next;
    res_pos <= res_pos_next;
    out_reg <= out_reg_next;
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    ql_next       = ql;
    qr_next       = qr;
    hk_next       = hk;
    dj_next       = dj;
    pend_next     = pend;
    acc_next      = acc;
    cur_next      = cur;
    delta_next    = delta;
    thresh_next   = thresh;
    res_sum_next  = res_sum;
    res_pos_next  = res_pos;
    out_reg_next  = out_reg;
    out_vld_next  = out_vld;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;
    sum_tmp       = '0;
    parent        = hk >> 1;
    hi_sat        = '0;

    // drop the output beat once taken
    if (out_vld && out_ready) begin
      out_vld_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == ADDR_W'(NODES - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          res_sum_next = '0;
          res_pos_next = '0;
          case (in_data.action)
            ACT_ADD: begin
              if (HEAP_W'(in_data.index_a) < HEAP_W'(LEAVES)) begin
                raddr      = ADDR_W'(LEAVES - 1) + ADDR_W'(in_data.index_a);
                hk_next    = HEAP_W'(LEAVES) + HEAP_W'(in_data.index_a);
                delta_next = in_data.value;
                state_next = ST_ADD_LEAF;
              end else begin
                raddr      = '0;
                state_next = ST_ROOT_RD;
              end
            end
            ACT_QUERY: begin
              hi_sat = (HEAP_W'(in_data.index_b) > HEAP_W'(LEAVES)) ?
                       HEAP_W'(LEAVES) : HEAP_W'(in_data.index_b);
              ql_next    = HEAP_W'(in_data.index_a) + HEAP_W'(LEAVES);
              qr_next    = hi_sat + HEAP_W'(LEAVES);
              acc_next   = '0;
              pend_next  = 1'b0;
              state_next = ST_QRY;
            end
            ACT_SEARCH: begin
              if (HEAP_W'(in_data.index_a) < HEAP_W'(LEAVES)) begin
                raddr       = ADDR_W'(LEAVES - 1) + ADDR_W'(in_data.index_a);
                dj_next     = in_data.index_a[LEAF_W-1:0];
                acc_next    = '0;
                thresh_next = in_data.value;
                state_next  = ST_SRCH;
              end else begin
                res_pos_next = POS_W'(LEAVES);
                state_next   = ST_FINISH;
              end
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end

      ST_ADD_LEAF: begin
        sum_tmp    = rdata + delta;
        we         = 1'b1;
        waddr      = ADDR_W'(hk - 1'b1);
        wdata      = sum_tmp;
        cur_next   = sum_tmp;
        raddr      = ADDR_W'((hk ^ HEAP_W'(1)) - 1'b1);
        state_next = ST_ADD_UP;
      end

      ST_ADD_UP: begin
        // sibling arrives: rebuild the parent, then fetch the parent's sibling unless the parent is the root
        sum_tmp  = cur + rdata;
        we       = 1'b1;
        waddr    = ADDR_W'(parent - 1'b1);
        wdata    = sum_tmp;
        cur_next = sum_tmp;
        hk_next  = parent;
        if (parent == HEAP_W'(1)) begin
          res_sum_next = sum_tmp;
          state_next   = ST_FINISH;
        end else begin
          raddr = ADDR_W'((parent ^ HEAP_W'(1)) - 1'b1);
        end
      end

      ST_ROOT_RD: begin
        res_sum_next = rdata;
        state_next   = ST_FINISH;
      end

      ST_QRY: begin
        sum_tmp  = pend ? (acc + rdata) : acc;
        acc_next = sum_tmp;
        if (ql < qr) begin
          if (ql[0]) begin
            raddr     = ADDR_W'(ql - 1'b1);
            ql_next   = ql + 1'b1;
            pend_next = 1'b1;
          end else if (qr[0]) begin
            raddr     = ADDR_W'(qr - HEAP_W'(2));
            qr_next   = qr - 1'b1;
            pend_next = 1'b1;
          end else begin
            ql_next   = ql >> 1;
            qr_next   = qr >> 1;
            pend_next = 1'b0;
          end
        end else begin
          pend_next    = 1'b0;
          res_sum_next = sum_tmp;
          state_next   = ST_FINISH;
        end
      end

      ST_SRCH: begin
        sum_tmp  = acc + rdata;
        acc_next = sum_tmp;
        if ($signed(sum_tmp) >= thresh) begin
          res_pos_next = POS_W'(dj) + 1'b1;
          state_next   = ST_FINISH;
        end else if (dj == LEAF_W'(LEAVES - 1)) begin
          res_pos_next = POS_W'(LEAVES);
          state_next   = ST_FINISH;
        end else begin
          raddr   = ADDR_W'(LEAVES) + ADDR_W'(dj);
          dj_next = dj + 1'b1;
        end
      end

      ST_FINISH: begin
        // hold until the output register is free
        if (!out_vld || out_ready) begin
          out_reg_next.sum_out      = res_sum;
          out_reg_next.position_out = res_pos;
          out_vld_next              = 1'b1;
          state_next                = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/stse_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module stse_ram #(
  parameter int DEPTH  = 2047,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
